@@ hw/rtl/sha256s_pkg.sv @@
// Shared constants, types and round functions of the SHA-256 stream hasher.
// Depends on nothing; used by the channel interfaces and the top level.
`default_nettype none

package sha256s_pkg;

    localparam int unsigned DigestPartW = 64;

    typedef logic [7:0][31:0] hash_words_t;

    localparam hash_words_t InitVector = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PadMarker  = 8'h80;
    localparam logic [5:0] LastLenPos = 6'd55;

    localparam logic FuncAbsorb   = 1'b0;
    localparam logic FuncFinalize = 1'b1;

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned s);
        ror = (x >> s) | (x << (32 - s));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        case (idx)
            6'd0:  round_const = 32'h428a2f98;
            6'd1:  round_const = 32'h71374491;
            6'd2:  round_const = 32'hb5c0fbcf;
            6'd3:  round_const = 32'he9b5dba5;
            6'd4:  round_const = 32'h3956c25b;
            6'd5:  round_const = 32'h59f111f1;
            6'd6:  round_const = 32'h923f82a4;
            6'd7:  round_const = 32'hab1c5ed5;
            6'd8:  round_const = 32'hd807aa98;
            6'd9:  round_const = 32'h12835b01;
            6'd10: round_const = 32'h243185be;
            6'd11: round_const = 32'h550c7dc3;
            6'd12: round_const = 32'h72be5d74;
            6'd13: round_const = 32'h80deb1fe;
            6'd14: round_const = 32'h9bdc06a7;
            6'd15: round_const = 32'hc19bf174;
            6'd16: round_const = 32'he49b69c1;
            6'd17: round_const = 32'hefbe4786;
            6'd18: round_const = 32'h0fc19dc6;
            6'd19: round_const = 32'h240ca1cc;
            6'd20: round_const = 32'h2de92c6f;
            6'd21: round_const = 32'h4a7484aa;
            6'd22: round_const = 32'h5cb0a9dc;
            6'd23: round_const = 32'h76f988da;
            6'd24: round_const = 32'h983e5152;
            6'd25: round_const = 32'ha831c66d;
            6'd26: round_const = 32'hb00327c8;
            6'd27: round_const = 32'hbf597fc7;
            6'd28: round_const = 32'hc6e00bf3;
            6'd29: round_const = 32'hd5a79147;
            6'd30: round_const = 32'h06ca6351;
            6'd31: round_const = 32'h14292967;
            6'd32: round_const = 32'h27b70a85;
            6'd33: round_const = 32'h2e1b2138;
            6'd34: round_const = 32'h4d2c6dfc;
            6'd35: round_const = 32'h53380d13;
            6'd36: round_const = 32'h650a7354;
            6'd37: round_const = 32'h766a0abb;
            6'd38: round_const = 32'h81c2c92e;
            6'd39: round_const = 32'h92722c85;
            6'd40: round_const = 32'ha2bfe8a1;
            6'd41: round_const = 32'ha81a664b;
            6'd42: round_const = 32'hc24b8b70;
            6'd43: round_const = 32'hc76c51a3;
            6'd44: round_const = 32'hd192e819;
            6'd45: round_const = 32'hd6990624;
            6'd46: round_const = 32'hf40e3585;
            6'd47: round_const = 32'h106aa070;
            6'd48: round_const = 32'h19a4c116;
            6'd49: round_const = 32'h1e376c08;
            6'd50: round_const = 32'h2748774c;
            6'd51: round_const = 32'h34b0bcb5;
            6'd52: round_const = 32'h391c0cb3;
            6'd53: round_const = 32'h4ed8aa4a;
            6'd54: round_const = 32'h5b9cca4f;
            6'd55: round_const = 32'h682e6ff3;
            6'd56: round_const = 32'h748f82ee;
            6'd57: round_const = 32'h78a5636f;
            6'd58: round_const = 32'h84c87814;
            6'd59: round_const = 32'h8cc70208;
            6'd60: round_const = 32'h90befffa;
            6'd61: round_const = 32'ha4506ceb;
            6'd62: round_const = 32'hbef9a3f7;
            6'd63: round_const = 32'hc67178f2;
            default: round_const = 32'h0;
        endcase
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sha256s_if.sv @@
// Valid/ready channel interfaces of the SHA-256 stream hasher: the byte input
// channel and the digest output channel. Depends on sha256s_pkg.
`default_nettype none

interface sha256s_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] msg_byte;

    modport source (output valid, output func, output msg_byte, input ready);
    modport sink   (input valid, input func, input msg_byte, output ready);
endinterface

interface sha256s_out_if;
    logic                               valid;
    logic                               ready;
    logic [sha256s_pkg::DigestPartW-1:0] digest_0;
    logic [sha256s_pkg::DigestPartW-1:0] digest_1;
    logic [sha256s_pkg::DigestPartW-1:0] digest_2;
    logic [sha256s_pkg::DigestPartW-1:0] digest_3;

    modport source (output valid, output digest_0, output digest_1, output digest_2,
                    output digest_3, input ready);
    modport sink   (input valid, input digest_0, input digest_1, input digest_2,
                    input digest_3, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sha256_stream_hasher.sv @@
// SHA-256 stream hasher top level: byte absorb, padding sequencer, one shared
// round unit and digest output register. Depends on sha256s_pkg, sha256s_if.
`default_nettype none

// Each input word either absorbs one message byte (func 0) or finalizes the
// message (func 1) and yields one 256-bit digest, big-endian, on the output
// channel; the hasher then starts a fresh message. An absorbed byte is taken
// while idle; the 64th byte of a block also runs the block through the single
// round unit: the rounds, then the chaining add. A finalize with p bytes
// pending pads and compresses the block; one block when p <= 55, otherwise
// two (the second holds only zero padding and the length). The round unit
// computes one SHA-256 round per cycle. The digest sits in an output register,
// so the next message streams in while it waits; a following finalize holds
// at its final add until the previous digest is taken. Input ready is high
// only while the sequencer idles.
module sha256_stream_hasher (
    input  wire               clk,
    input  wire               rst_n,
    sha256s_in_if.sink        in_ch,
    sha256s_out_if.source     out_ch
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD
    } seq_state_t;

    seq_state_t               state_reg, state_next;
    sha256s_pkg::hash_words_t chain_reg, chain_next;
    sha256s_pkg::hash_words_t work_reg, work_next;
    logic [511:0]             blk_reg, blk_next;
    logic [60:0]              byte_cnt_reg, byte_cnt_next;
    logic [63:0]              len_reg, len_next;
    logic [5:0]               pos_reg, pos_next;
    logic [5:0]               rnd_reg, rnd_next;
    logic                     first_reg, first_next;
    logic                     fin_reg, fin_next;
    logic                     len_blk_reg, len_blk_next;
    logic                     out_valid_reg, out_valid_next;
    logic [255:0]             digest_reg, digest_next;

    logic                     in_acc;
    logic                     out_busy;
    logic [7:0]               pad_byte;
    logic                     len_byte;
    logic [31:0]              w_top;
    logic [31:0]              w_new;
    logic [31:0]              t1;
    logic [31:0]              t2;
    logic [31:0]              ch_val;
    logic [31:0]              maj_val;
    sha256s_pkg::hash_words_t sum_words;

    assign in_ch.ready     = (state_reg == ST_IDLE);
    assign in_acc          = in_ch.valid && in_ch.ready;
    assign out_busy        = out_valid_reg && !out_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.digest_0 = digest_reg[255:192];
    assign out_ch.digest_1 = digest_reg[191:128];
    assign out_ch.digest_2 = digest_reg[127:64];
    assign out_ch.digest_3 = digest_reg[63:0];

    assign len_byte = len_blk_reg && !first_reg && (pos_reg[5:3] == 3'b111);
    assign pad_byte = first_reg ? sha256s_pkg::PadMarker : (len_byte ? len_reg[63:56] : 8'h00);

    // round unit and message schedule over the block shift register
    assign w_top   = blk_reg[511:480];
    assign w_new   = sha256s_pkg::small_sig1(blk_reg[63:32]) + blk_reg[223:192]
                   + sha256s_pkg::small_sig0(blk_reg[479:448]) + w_top;
    assign ch_val  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign maj_val = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                   ^ (work_reg[1] & work_reg[2]);
    assign t1      = work_reg[7] + sha256s_pkg::big_sig1(work_reg[4]) + ch_val
                   + sha256s_pkg::round_const(rnd_reg) + w_top;
    assign t2      = sha256s_pkg::big_sig0(work_reg[0]) + maj_val;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            sum_words[i] = chain_reg[i] + work_reg[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        blk_next       = blk_reg;
        byte_cnt_next  = byte_cnt_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        rnd_next       = rnd_reg;
        first_next     = first_reg;
        fin_next       = fin_reg;
        len_blk_next   = len_blk_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        digest_next    = digest_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.func == sha256s_pkg::FuncAbsorb)
                    begin
                        blk_next      = {blk_reg[503:0], in_ch.msg_byte};
                        byte_cnt_next = byte_cnt_reg + 61'd1;
                        if (byte_cnt_reg[5:0] == 6'd63)
                        begin
                            work_next  = chain_reg;
                            rnd_next   = 6'd0;
                            state_next = ST_ROUND;
                        end
                    end
                    else
                    begin
                        pos_next     = byte_cnt_reg[5:0];
                        first_next   = 1'b1;
                        fin_next     = 1'b1;
                        len_blk_next = (byte_cnt_reg[5:0] <= sha256s_pkg::LastLenPos);
                        len_next     = {byte_cnt_reg, 3'b000};
                        state_next   = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                blk_next   = {blk_reg[503:0], pad_byte};
                first_next = 1'b0;
                pos_next   = pos_reg + 6'd1;
                if (len_byte)
                begin
                    len_next = {len_reg[55:0], 8'h00};
                end
                if (pos_reg == 6'd63)
                begin
                    work_next  = chain_reg;
                    rnd_next   = 6'd0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                work_next = {work_reg[6:0], t1 + t2};
                work_next[4] = work_reg[3] + t1;
                blk_next  = {blk_reg[479:0], w_new};
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (fin_reg && len_blk_reg)
                begin
                    // hold until the previous digest is taken
                    if (!out_busy)
                    begin
                        digest_next    = {sum_words[0], sum_words[1], sum_words[2],
                                          sum_words[3], sum_words[4], sum_words[5],
                                          sum_words[6], sum_words[7]};
                        out_valid_next = 1'b1;
                        chain_next     = sha256s_pkg::InitVector;
                        byte_cnt_next  = 61'd0;
                        fin_next       = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    chain_next = sum_words;
                    if (fin_reg)
                    begin
                        len_blk_next = 1'b1;
                        state_next   = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chain_reg     <= sha256s_pkg::InitVector;
            byte_cnt_reg  <= 61'd0;
            pos_reg       <= 6'd0;
            rnd_reg       <= 6'd0;
            first_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            len_blk_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            digest_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            byte_cnt_reg  <= byte_cnt_next;
            pos_reg       <= pos_next;
            rnd_reg       <= rnd_next;
            first_reg     <= first_next;
            fin_reg       <= fin_next;
            len_blk_reg   <= len_blk_next;
            out_valid_reg <= out_valid_next;
            digest_reg    <= digest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        blk_reg    <= blk_next;
        len_reg    <= len_next;
    end

    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_ch.func == sha256s_pkg::FuncFinalize)) |=> !in_ch.ready)
        else $error("ready high right after a finalize word");

    a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_ch.func == sha256s_pkg::FuncAbsorb) && (byte_cnt_reg[5:0] == 6'd63))
        |=> (state_reg == ST_ROUND) && (rnd_reg == 6'd0))
        else $error("full block did not start compression");

    a_digest_resets_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (chain_reg == sha256s_pkg::InitVector)
                                 && (byte_cnt_reg == 61'd0) && !fin_reg)
        else $error("hash state not restarted after digest");

endmodule

`default_nettype wire
